// ----- hdl/test_pattern_pixel_generator_core_assert.svh -----
// Assertion macros shared by the checker of the pattern generator.
// Each macro expects i_clk and i_rst_n in scope; TPG_ASSERT_LATENCY also needs the package constant PIPE_DEPTH.
`ifndef TEST_PATTERN_PIXEL_GENERATOR_CORE_ASSERT_SVH
`define TEST_PATTERN_PIXEL_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPG_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("%m: check failed");

// Implication checked exactly one pipeline latency later.
`define TPG_ASSERT_LATENCY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##PIPE_DEPTH (cons)) else $error("%m: latency check failed");

`endif

// ----- hdl/tpg_pkg.sv -----
`default_nettype none

package tpg_pkg;

    // Frame geometry.
    localparam int unsigned MAX_DIMENSION = 4096;
    localparam int unsigned DIM_W         = 13;
    localparam int unsigned COORD_W       = 12;
    localparam int unsigned HALF_W        = DIM_W - 1;
    localparam int unsigned CHAN_W        = 8;

    // Vignette arithmetic widths.
    localparam int unsigned SQ_W   = 23;   // (MAX_DIMENSION/2)^2 needs 23 bits
    localparam int unsigned PROD_W = 45;   // product of two squares
    localparam int unsigned SUM_W  = 46;   // sum of two products
    localparam int unsigned DIV_W  = 56;   // 800 * sum + denominator
    localparam int unsigned QUO_W  = 8;    // quotient bits kept

    // Edge glow.
    localparam int unsigned LEVEL_W = 9;
    localparam int unsigned SHIFT_W = 5;
    localparam logic [LEVEL_W-1:0] GLOW_BASE      = 9'h1FF;
    localparam logic [SHIFT_W-1:0] GLOW_MAX_SHIFT = 5'd31;

    // Darkening term limits.
    localparam int unsigned DARK_W = 6;
    localparam logic [DARK_W-1:0] DARK_MAX = 6'd50;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // Register pipeline depth from request acceptance to result strobe.
    localparam int unsigned PIPE_DEPTH = 15;

    // Configuration register map.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } t_pixel_req;

    typedef struct packed {
        logic [CHAN_W-1:0] red_level;
        logic [CHAN_W-1:0] green_level;
        logic [CHAN_W-1:0] blue_level;
        logic              outside_frame;
    } t_pixel_res;

endpackage

`default_nettype wire

// ----- hdl/test_pattern_pixel_generator_core.sv -----
`default_nettype none
// Test-pattern pixel generator.
//
// A request carries one pixel coordinate (i_req) and is accepted at a rising
// edge where start is high and busy is low. The block returns the color of
// the test pattern at that pixel on o_res, marked by o_res_strobe for exactly
// one cycle. Every request yields exactly one result, in request order.
//
// Throughput is one request per cycle while busy is low; the figure comes
// from a 15-stage register pipeline in which the vignette quotient is
// resolved one bit per stage by eight compare-and-subtract stages.
//
// Frame width and height are written over the config channel (i_cfg_valid/
// o_cfg_ready, i_cfg_index, i_cfg_data), by the user only while no request is
// in flight, not enforced by the block. Unknown-index writes are dropped.
//
// Synchronous reset clears the pipeline and restores a 640 by 480 frame;
// busy is high during reset and until r_run is registered after it, and low
// otherwise. The receiver cannot stall, so results are presented only once.
module test_pattern_pixel_generator_core import tpg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  t_pixel_req           i_req,
    output logic                 busy,
    output logic                 o_res_strobe,
    output t_pixel_res           o_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    // Values that ride along the pipeline untouched until the final stage.
    typedef struct packed {
        logic               outside;
        logic [LEVEL_W-1:0] level;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
    } t_side;

    localparam int unsigned SIDE_LAST = PIPE_DEPTH - 1;

    logic               r_run;
    logic [DIM_W-1:0]   r_frame_width;
    logic [DIM_W-1:0]   r_frame_height;
    logic [PIPE_DEPTH:1] r_vld;
    t_side              r_side [1:SIDE_LAST];
    t_pixel_res         r_res;

    // The block is ready once r_run has been set after reset is released.
    assign o_cfg_ready  = r_run & i_rst_n;
    assign busy         = ~o_cfg_ready;
    assign o_res_strobe = r_vld[PIPE_DEPTH];
    assign o_res        = r_res;

    logic req_accept;
    assign req_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run          <= 1'b0;
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_vld          <= '0;
        end else begin
            r_run <= 1'b1;
            r_vld <= {r_vld[PIPE_DEPTH-1:1], req_accept};
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                    REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: clamp the frame, find the halves, the distances to the
    // center, the distance to the nearest edge and the base color.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   w_eff, h_eff;
    logic [HALF_W-1:0]  hw, hh, dx, dy;
    logic [DIM_W-1:0]   edge_r, edge_b, dist_a, dist_b, dist_min;
    logic [SHIFT_W-1:0] glow_shift;
    logic [COORD_W-1:0] px, py;
    t_side              side_in;

    assign px = i_req.pixel_x;
    assign py = i_req.pixel_y;

    always_comb begin
        w_eff = (r_frame_width > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION)
                                                         : r_frame_width;
        h_eff = (r_frame_height > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION)
                                                          : r_frame_height;
        // A frame of size 0 or 1 has a half of 0, which is taken as 1.
        hw = (w_eff[DIM_W-1:1] == '0) ? HALF_W'(1) : w_eff[DIM_W-1:1];
        hh = (h_eff[DIM_W-1:1] == '0) ? HALF_W'(1) : h_eff[DIM_W-1:1];
        dx = (px >= hw) ? (px - hw) : (hw - px);
        dy = (py >= hh) ? (py - hh) : (hh - py);

        // Only meaningful for in-frame pixels, where they cannot wrap.
        edge_r   = w_eff - DIM_W'(1) - {1'b0, px};
        edge_b   = h_eff - DIM_W'(1) - {1'b0, py};
        dist_a   = (px < py) ? {1'b0, px} : {1'b0, py};
        dist_b   = (edge_r < edge_b) ? edge_r : edge_b;
        dist_min = (dist_a < dist_b) ? dist_a : dist_b;
        glow_shift = (dist_min > DIM_W'(GLOW_MAX_SHIFT)) ? GLOW_MAX_SHIFT
                                                         : dist_min[SHIFT_W-1:0];

        side_in.outside = ({1'b0, px} >= w_eff) || ({1'b0, py} >= h_eff);
        side_in.level   = GLOW_BASE >> glow_shift;
        side_in.red     = ~px[CHAN_W-1:0] & ~py[CHAN_W-1:0];
        side_in.green   =  px[CHAN_W-1:0] & ~py[CHAN_W-1:0];
        side_in.blue    = ~px[CHAN_W-1:0] &  py[CHAN_W-1:0];
    end

    logic [HALF_W-1:0] r1_dx, r1_dy, r1_hw, r1_hh;

    always_ff @(posedge i_clk) begin
        r1_dx     <= dx;
        r1_dy     <= dy;
        r1_hw     <= hw;
        r1_hh     <= hh;
        r_side[1] <= side_in;
        for (int i = 2; i <= SIDE_LAST; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares of the offsets and of the halves.
    // ------------------------------------------------------------------
    logic [2*HALF_W-1:0] dx2_full, dy2_full, hw2_full, hh2_full;
    logic [SQ_W-1:0]     r2_dx2, r2_dy2, r2_hw2, r2_hh2;

    assign dx2_full = r1_dx * r1_dx;
    assign dy2_full = r1_dy * r1_dy;
    assign hw2_full = r1_hw * r1_hw;
    assign hh2_full = r1_hh * r1_hh;

    always_ff @(posedge i_clk) begin
        r2_dx2 <= dx2_full[SQ_W-1:0];
        r2_dy2 <= dy2_full[SQ_W-1:0];
        r2_hw2 <= hw2_full[SQ_W-1:0];
        r2_hh2 <= hh2_full[SQ_W-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 3: cross products for the numerator and the denominator.
    // The ellipse test x'^2/hw^2 + y'^2/hh^2 is scaled by hw^2*hh^2.
    // ------------------------------------------------------------------
    logic [2*SQ_W-1:0] a_full, b_full, den_full;
    logic [PROD_W-1:0] r3_a, r3_b, r3_den;

    assign a_full   = r2_dx2 * r2_hh2;
    assign b_full   = r2_dy2 * r2_hw2;
    assign den_full = r2_hw2 * r2_hh2;

    always_ff @(posedge i_clk) begin
        r3_a   <= a_full[PROD_W-1:0];
        r3_b   <= b_full[PROD_W-1:0];
        r3_den <= den_full[PROD_W-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 4: numerator = 800 * (a + b), as 512 + 256 + 32 shifted terms.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] ab_sum;
    logic [DIV_W-1:0] num_next;
    logic [DIV_W-1:0] r4_num;
    logic [PROD_W-1:0] r4_den;

    assign ab_sum   = SUM_W'(r3_a) + SUM_W'(r3_b);
    assign num_next = (DIV_W'(ab_sum) << 9) + (DIV_W'(ab_sum) << 8)
                    + (DIV_W'(ab_sum) << 5);

    always_ff @(posedge i_clk) begin
        r4_num <= num_next;
        r4_den <= r3_den;
    end

    // ------------------------------------------------------------------
    // Stage 5: bias the dividend so that the floor quotient is the ceiling.
    // ------------------------------------------------------------------
    logic [DIV_W-1:0]  r5_rem;
    logic [PROD_W-1:0] r5_den;

    always_ff @(posedge i_clk) begin
        r5_rem <= r4_num + DIV_W'(r4_den) - DIV_W'(1);
        r5_den <= r4_den;
    end

    // ------------------------------------------------------------------
    // Stage 6: saturation check. Any quotient of 256 or more darkens
    // nothing, so only eight quotient bits are resolved afterwards.
    // Stages 7 to 14: restoring division, one quotient bit per stage.
    // ------------------------------------------------------------------
    logic [DIV_W-1:0]  r_rem  [0:QUO_W];
    logic [PROD_W-1:0] r_dden [0:QUO_W];
    logic [QUO_W-1:0]  r_quo  [0:QUO_W];
    logic              r_sat  [0:QUO_W];

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= r5_rem;
        r_dden[0] <= r5_den;
        r_quo[0]  <= '0;
        r_sat[0]  <= r5_rem >= (DIV_W'(r5_den) << QUO_W);
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        localparam int unsigned BIT = QUO_W - 1 - j;
        logic [DIV_W-1:0] den_sh;
        logic             fits;

        assign den_sh = DIV_W'(r_dden[j]) << BIT;
        assign fits   = r_rem[j] >= den_sh;

        always_ff @(posedge i_clk) begin
            r_rem[j+1]  <= fits ? (r_rem[j] - den_sh) : r_rem[j];
            r_dden[j+1] <= r_dden[j];
            r_quo[j+1]  <= {r_quo[j][QUO_W-2:0], fits};
            r_sat[j+1]  <= r_sat[j];
        end
    end

    // ------------------------------------------------------------------
    // Stage 15: darkening term, per-channel clamp and the output register.
    // ------------------------------------------------------------------
    function automatic logic [CHAN_W-1:0] f_channel(
        input logic [CHAN_W-1:0]  c,
        input logic [DARK_W-1:0]  d,
        input logic [LEVEL_W-1:0] lvl
    );
        logic signed [LEVEL_W+1:0] v;
        logic signed [LEVEL_W+1:0] lv;
        v  = $signed({3'b000, c}) - $signed({5'b00000, d});
        lv = $signed({2'b00, lvl});
        if (v < lv) begin
            v = lv;
        end
        if (v > $signed({3'b000, CHAN_MAX})) begin
            return CHAN_MAX;
        end
        return v[CHAN_W-1:0];
    endfunction

    logic [QUO_W-1:0]  quo;
    logic [DARK_W-1:0] dark;
    logic [CHAN_W-1:0] dark_diff;
    t_side             side_out;

    assign quo       = r_quo[QUO_W];
    assign side_out  = r_side[SIDE_LAST];
    assign dark_diff = CHAN_MAX - quo;

    always_comb begin
        if (r_sat[QUO_W] || (quo == CHAN_MAX)) begin
            dark = '0;
        end else if (dark_diff >= CHAN_W'(DARK_MAX)) begin
            dark = DARK_MAX;
        end else begin
            dark = dark_diff[DARK_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (side_out.outside) begin
            r_res <= '{red_level: '0, green_level: '0, blue_level: '0,
                       outside_frame: 1'b1};
        end else begin
            r_res.red_level     <= f_channel(side_out.red,   dark, side_out.level);
            r_res.green_level   <= f_channel(side_out.green, dark, side_out.level);
            r_res.blue_level    <= f_channel(side_out.blue,  dark, side_out.level);
            r_res.outside_frame <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tpg_checker.sv -----
`default_nettype none
`include "test_pattern_pixel_generator_core_assert.svh"

module tpg_checker import tpg_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_res_strobe,
    input t_pixel_res o_res
);

    // Every accepted request produces a result after the fixed latency.
    `TPG_ASSERT_LATENCY(a_result_follows, start && !busy, o_res_strobe)

    // No result appears without a request accepted one latency earlier.
    `TPG_ASSERT_IMPL(a_no_spurious, o_res_strobe, $past(start && !busy, PIPE_DEPTH))

    // Out-of-frame pixels are black.
    `TPG_ASSERT_IMPL(a_outside_black, o_res_strobe && o_res.outside_frame, (o_res.red_level == '0) && (o_res.green_level == '0) && (o_res.blue_level == '0))

endmodule

bind test_pattern_pixel_generator_core tpg_checker u_tpg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_res_strobe (o_res_strobe),
    .o_res        (o_res)
);

`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none

// Self-checking bench for the test pattern pixel generator.
//
// Pixel requests are queued up front by the sequencing block below and fed to
// the block by a clocked driver, one request per start/busy handshake. Every
// request the block takes is run through a local predictor of the pattern.
// The predicted color is appended to a queue of expected pixels. A clocked
// monitor pops that queue for every result strobe and compares all four
// fields. Frame width and height are only rewritten while the pipeline is
// empty, so the predictor always sees the register values the block used.
module testbench;
    import tpg_pkg::*;

    // Indexes that the register map leaves unassigned. Writes to them must be
    // dropped by the block.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // Largest idle gap the driver draws after each request it presents.
    localparam int unsigned MAX_GAP = 15;
    // Request budget for the frame batches that follow the directed part.
    localparam int unsigned RANDOM_REQUESTS = 600;
    // Hard stop for a hung run.
    localparam int unsigned RUN_LIMIT = 400_000;
    // Width of one packed request.
    localparam int unsigned REQ_W = $bits(t_pixel_req);

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    t_pixel_req           i_req = '0;
    logic                 busy;
    logic                 o_res_strobe;
    t_pixel_res           o_res;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DIM_W-1:0]     i_cfg_data = '0;

    // Requests waiting to be driven, and colors waiting to come back.
    t_pixel_req pixel_requests[$];
    t_pixel_res expected_pixels[$];

    // Local copy of the two frame registers, updated at each accepted write.
    logic [DIM_W-1:0] model_width = FRAME_WIDTH_RST;
    logic [DIM_W-1:0] model_height = FRAME_HEIGHT_RST;

    // n_presented counts requests put on the port, n_accepted those the
    // block has taken. They differ while a request waits for its handshake.
    int unsigned n_presented = 0;
    int unsigned n_accepted = 0;
    int unsigned n_cfg_writes = 0;
    int unsigned gap_left = 0;
    int unsigned n_errors = 0;
    logic        sender_gaps_on = 1'b1;

    test_pattern_pixel_generator_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_req        (i_req),
        .busy         (busy),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // One color channel: the base value darkened by the vignette, lifted to
    // at least the edge glow, and clipped to full scale.
    function automatic logic [CHAN_W-1:0] shade(input int base, input int dark, input int glow);
        int v;
        v = base - dark;
        if (v < glow) v = glow;
        if (v > int'(CHAN_MAX)) v = int'(CHAN_MAX);
        return v[CHAN_W-1:0];
    endfunction

    // Predicted pattern color for one pixel under the given frame registers.
    function automatic t_pixel_res pattern_pixel(input t_pixel_req px,
                                                 input logic [DIM_W-1:0] width_reg,
                                                 input logic [DIM_W-1:0] height_reg);
        t_pixel_res       res;
        int unsigned      w, h, x, y, edge_dist;
        bit [DIV_W-1:0]   hw, hh, dx, dy, hw2, hh2, num, den, quo;
        int               dark, glow;

        // Oversized registers are clamped to the largest supported frame.
        w = (width_reg > MAX_DIMENSION) ? MAX_DIMENSION : 32'(width_reg);
        h = (height_reg > MAX_DIMENSION) ? MAX_DIMENSION : 32'(height_reg);
        x = 32'(px.pixel_x);
        y = 32'(px.pixel_y);
        res = '0;
        if (x >= w || y >= h) begin
            res.outside_frame = 1'b1;
            return res;
        end

        // The glow shift is the distance to the nearest border, capped.
        edge_dist = x;
        if (y < edge_dist) edge_dist = y;
        if (w - 1 - x < edge_dist) edge_dist = w - 1 - x;
        if (h - 1 - y < edge_dist) edge_dist = h - 1 - y;
        if (edge_dist > GLOW_MAX_SHIFT) edge_dist = 32'(GLOW_MAX_SHIFT);
        glow = int'(GLOW_BASE >> edge_dist);

        // Vignette: a one or zero wide frame still uses a half size of one.
        hw = DIV_W'(w / 2);
        hh = DIV_W'(h / 2);
        if (hw == 0) hw = DIV_W'(1);
        if (hh == 0) hh = DIV_W'(1);
        dx = (DIV_W'(x) >= hw) ? DIV_W'(x) - hw : hw - DIV_W'(x);
        dy = (DIV_W'(y) >= hh) ? DIV_W'(y) - hh : hh - DIV_W'(y);
        hw2 = hw * hw;
        hh2 = hh * hh;
        num = DIV_W'(800) * (dx * dx * hh2 + dy * dy * hw2);
        den = hw2 * hh2;
        quo = (num + den - DIV_W'(1)) / den;
        if (quo >= CHAN_MAX) begin
            dark = 0;
        end else begin
            dark = int'(CHAN_MAX) - int'(quo);
            if (dark > int'(DARK_MAX)) dark = int'(DARK_MAX);
        end

        res.red_level   = shade(int'(~x & ~y & 32'hFF), dark, glow);
        res.green_level = shade(int'(x & ~y & 32'hFF), dark, glow);
        res.blue_level  = shade(int'(~x & y & 32'hFF), dark, glow);
        return res;
    endfunction

    task automatic check_field(input string field, input logic [CHAN_W-1:0] want,
                               input logic [CHAN_W-1:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Request driver. Inputs change on the falling edge. A request stays on
    // the port until the monitor has seen it taken; after that the driver
    // idles for the gap drawn for that request before offering the next one.
    // While start is low the coordinate lines carry junk, which the block
    // must ignore.
    always @(negedge i_clk) begin : drive_requests
        t_pixel_req next_req;
        logic       next_start;
        next_req = i_req;
        next_start = start;
        if (!i_rst_n) begin
            next_start = 1'b0;
        end else if (n_presented == n_accepted) begin
            next_start = 1'b0;
            next_req = REQ_W'($urandom);
            if (gap_left != 0) begin
                gap_left--;
            end else if (pixel_requests.size() != 0) begin
                next_req = pixel_requests.pop_front();
                next_start = 1'b1;
                n_presented++;
                gap_left = sender_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            end
        end
        start <= next_start;
        i_req <= next_req;
    end

    // Monitor. Everything is sampled on the rising edge, before the block's
    // registers move. A result is checked before a request taken at the same
    // edge is predicted, so a stray result can never match a fresh entry.
    always @(posedge i_clk) begin : watch_ports
        t_pixel_res want;
        if (i_rst_n) begin
            if (o_res_strobe) begin
                if (expected_pixels.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, o_res);
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("red_level", want.red_level, o_res.red_level);
                    check_field("green_level", want.green_level, o_res.green_level);
                    check_field("blue_level", want.blue_level, o_res.blue_level);
                    check_field("outside_frame", CHAN_W'(want.outside_frame),
                                CHAN_W'(o_res.outside_frame));
                end
            end
            if (start && !busy) begin
                expected_pixels.push_back(pattern_pixel(i_req, model_width, model_height));
                n_accepted++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH: begin
                        model_width = i_cfg_data;
                    end
                    REG_FRAME_HEIGHT: begin
                        model_height = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
                n_cfg_writes++;
            end
        end
    end

    // One register write. Valid is raised on a falling edge and dropped on
    // the first falling edge after the monitor has counted the handshake.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [DIM_W-1:0] value);
        int unsigned writes_before;
        writes_before = n_cfg_writes;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        do @(negedge i_clk); while (n_cfg_writes == writes_before);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every queued request was taken and every color came back.
    task automatic wait_idle();
        while (pixel_requests.size() != 0 || n_presented != n_accepted ||
               expected_pixels.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // A random request shaped for the current frame: mostly inside it, some
    // hugging the borders where the glow lives, the rest anywhere at all.
    function automatic t_pixel_req pick_pixel();
        t_pixel_req  px;
        int unsigned w, h, sel, off;
        w = (model_width > MAX_DIMENSION) ? MAX_DIMENSION : 32'(model_width);
        h = (model_height > MAX_DIMENSION) ? MAX_DIMENSION : 32'(model_height);
        sel = $urandom_range(0, 9);
        px = REQ_W'($urandom);
        if (w != 0 && h != 0 && sel < 6) begin
            px.pixel_x = COORD_W'($urandom_range(0, w - 1));
            px.pixel_y = COORD_W'($urandom_range(0, h - 1));
        end else if (w != 0 && h != 0 && sel < 8) begin
            off = $urandom_range(0, 40);
            px.pixel_x = COORD_W'((off >= w) ? 0 : ($urandom_range(0, 1) ? off : w - 1 - off));
            off = $urandom_range(0, 40);
            px.pixel_y = COORD_W'((off >= h) ? 0 : ($urandom_range(0, 1) ? off : h - 1 - off));
        end
        return px;
    endfunction

    // Rewrite both frame registers on an idle block, then run a batch of
    // random requests through it.
    task automatic run_frame(input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height,
                             input int unsigned count, input logic gaps_on);
        write_register(REG_FRAME_WIDTH, width);
        write_register(REG_FRAME_HEIGHT, height);
        sender_gaps_on = gaps_on;
        repeat (count) pixel_requests.push_back(pick_pixel());
        wait_idle();
    endtask

    // Sequencing: reset, directed corners at the reset geometry, a degenerate
    // one-row frame with writes to the unused indexes, then random frames.
    initial begin : sequence_run
        int unsigned issued;
        int unsigned batch;
        int unsigned sel;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry, 640 by 480: the four corners, the center and its
        // neighbor, the first coordinates past each edge, the far corner of
        // the coordinate space, both sides of the glow shift cap, and
        // alternating bit patterns for the AND/NOT base colors.
        pixel_requests.push_back('{pixel_x: 12'd0,    pixel_y: 12'd0});
        pixel_requests.push_back('{pixel_x: 12'd639,  pixel_y: 12'd479});
        pixel_requests.push_back('{pixel_x: 12'd639,  pixel_y: 12'd0});
        pixel_requests.push_back('{pixel_x: 12'd0,    pixel_y: 12'd479});
        pixel_requests.push_back('{pixel_x: 12'd320,  pixel_y: 12'd240});
        pixel_requests.push_back('{pixel_x: 12'd319,  pixel_y: 12'd239});
        pixel_requests.push_back('{pixel_x: 12'd640,  pixel_y: 12'd0});
        pixel_requests.push_back('{pixel_x: 12'd0,    pixel_y: 12'd480});
        pixel_requests.push_back('{pixel_x: 12'hFFF,  pixel_y: 12'hFFF});
        pixel_requests.push_back('{pixel_x: 12'd31,   pixel_y: 12'd200});
        pixel_requests.push_back('{pixel_x: 12'd32,   pixel_y: 12'd200});
        pixel_requests.push_back('{pixel_x: 12'd100,  pixel_y: 12'd31});
        pixel_requests.push_back('{pixel_x: 12'h0AA,  pixel_y: 12'h055});
        pixel_requests.push_back('{pixel_x: 12'h155,  pixel_y: 12'h0AA});
        pixel_requests.push_back('{pixel_x: 12'h0FF,  pixel_y: 12'd0});
        pixel_requests.push_back('{pixel_x: 12'd0,    pixel_y: 12'h0FF});
        wait_idle();

        // An oversized width clamps to the maximum, and a height of one
        // forces the half height up to one. Writes to the spare indexes in
        // between must leave both registers alone.
        write_register(REG_FRAME_WIDTH, 13'h1FFF);
        write_register(REG_FRAME_HEIGHT, 13'd1);
        write_register(REG_SPARE_A, 13'd0);
        write_register(REG_SPARE_B, 13'h1FFF);
        pixel_requests.push_back('{pixel_x: 12'd0,    pixel_y: 12'd0});
        pixel_requests.push_back('{pixel_x: 12'hFFF,  pixel_y: 12'd0});
        pixel_requests.push_back('{pixel_x: 12'd2048, pixel_y: 12'd0});
        pixel_requests.push_back('{pixel_x: 12'd100,  pixel_y: 12'd1});
        wait_idle();

        // Fixed extremes first: largest frame, smallest legal frame, the
        // one-pixel frame, zero sizes that put every pixel outside, and
        // lopsided frames. Gaps stay off on some of them for back-to-back
        // traffic through the whole pipeline.
        issued = 0;
        run_frame(13'd4096, 13'd4096, 60, 1'b1);
        run_frame(13'd2, 13'd2, 30, 1'b0);
        run_frame(13'd1, 13'd1, 20, 1'b1);
        run_frame(13'd0, 13'd100, 20, 1'b0);
        run_frame(13'd100, 13'd0, 20, 1'b1);
        run_frame(13'd8191, 13'd4097, 50, 1'b0);
        run_frame(13'd2, 13'd4096, 30, 1'b1);
        run_frame(13'd4096, 13'd3, 30, 1'b1);
        issued = 260;

        // Then random geometries, mostly modest sizes, until the request
        // budget is spent.
        while (issued < RANDOM_REQUESTS) begin
            sel = $urandom_range(0, 3);
            if (sel == 0) begin
                width = DIM_W'($urandom_range(0, 8191));
                height = DIM_W'($urandom_range(0, 8191));
            end else if (sel == 3) begin
                width = DIM_W'($urandom_range(2, 64));
                height = DIM_W'($urandom_range(2, 64));
            end else begin
                width = DIM_W'($urandom_range(2, 1024));
                height = DIM_W'($urandom_range(2, 1024));
            end
            batch = $urandom_range(20, 60);
            run_frame(width, height, batch, $urandom_range(0, 3) != 0);
            issued += batch;
        end

        // Leave room for any stray result to show up after the last one.
        repeat (PIPE_DEPTH + 5) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("test_pattern_pixel_generator_core regression: pass");
        end else begin
            $display("test_pattern_pixel_generator_core regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("test_pattern_pixel_generator_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
